FILE: hw/rtl/dss_pkg.sv
// Shared types and constants of the drum step sequencer.
// Used by dss_ctrl, dss_datapath and drum_step_sequencer; depends on nothing.
`timescale 1ns / 1ps

package dss_pkg;

	// Default sizes of the pattern store
	localparam int DEF_TRACKS    = 16;
	localparam int DEF_MAX_STEPS = 64;

	// Field widths
	localparam int VEL_W  = 7;
	localparam int CFG_W  = 7;
	localparam int POT_W  = 10;

	// Velocities and pitch
	localparam logic [VEL_W-1:0] KEY_VEL    = 7'd75;
	localparam logic [VEL_W-1:0] PRESS_VEL  = 7'd80;
	localparam logic [6:0]       PITCH_BASE = 7'd66;

	// Pot scaling: pot * 126 / 1027 via a rounded-up reciprocal, exact for 10-bit input
	localparam int POT_SHIFT = 20;
	localparam int POT_RECIP = (126 * (2 ** POT_SHIFT) + 1027 - 1) / 1027;
	localparam int RECIP_W   = 17;
	localparam int PROD_W    = POT_W + RECIP_W;

	// Register reset values
	localparam logic [6:0] LEN_RESET = 7'd8;
	localparam logic [4:0] DIV_RESET = 5'd6;

	// Configuration register indexes
	localparam logic [1:0] REG_PATTERN_LENGTH   = 2'd0;
	localparam logic [1:0] REG_CLOCK_DIVIDE     = 2'd1;
	localparam logic [1:0] REG_MIDI_SYNC_ENABLE = 2'd2;

	// Command codes
	localparam logic [2:0] CMD_MIDI_CLOCK = 3'd0;
	localparam logic [2:0] CMD_MIDI_STOP  = 3'd1;
	localparam logic [2:0] CMD_INT_TICK   = 3'd2;
	localparam logic [2:0] CMD_KEY        = 3'd3;
	localparam logic [2:0] CMD_POT        = 3'd4;
	localparam logic [2:0] CMD_SWITCH     = 3'd5;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_OFF,
		ST_ON,
		ST_KEY,
		ST_POT
	} dss_state_t;

	// Controller to datapath
	typedef struct packed {
		logic accept;
		logic cnt_clear;
		logic cnt_inc;
		logic emit_off;
		logic emit_on;
		logic emit_key;
		logic pot_write;
	} dss_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic adv_go;
		logic key_go;
		logic pot_go;
		logic cnt_last;
		logic row_any;
	} dss_status_t;

endpackage

FILE: hw/rtl/dss_ctrl.sv
// Controller state machine of the drum step sequencer.
// Sequences advances, key presses and pot updates; depends on dss_pkg.
`timescale 1ns / 1ps

module dss_ctrl
	import dss_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  dss_status_t sts,
	output dss_cmd_t    ctl
);

	dss_state_t state_q;
	dss_state_t state_d;
	logic       accept;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;

	// Hold state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					priority if (sts.adv_go) begin
						state_d = ST_OFF;
					end else if (sts.key_go) begin
						state_d = ST_KEY;
					end else if (sts.pot_go) begin
						state_d = ST_POT;
					end
				end
			end
			ST_OFF: begin
				if (sts.cnt_last) begin
					state_d = sts.row_any ? ST_ON : ST_IDLE;
				end
			end
			ST_ON: begin
				if (sts.cnt_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_KEY:  state_d = ST_IDLE;
			ST_POT:  state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// Datapath commands
	always_comb begin
		ctl           = '0;
		ctl.accept    = accept;
		unique case (state_q)
			ST_IDLE: begin
				ctl.cnt_clear = 1'b1;
			end
			ST_OFF: begin
				ctl.emit_off  = 1'b1;
				ctl.cnt_inc   = 1'b1;
				ctl.cnt_clear = sts.cnt_last;
			end
			ST_ON: begin
				ctl.emit_on = 1'b1;
				ctl.cnt_inc = 1'b1;
			end
			ST_KEY: begin
				ctl.emit_key = 1'b1;
			end
			ST_POT: begin
				ctl.pot_write = 1'b1;
			end
			default: begin
				ctl.cnt_clear = 1'b1;
			end
		endcase
	end

endmodule

FILE: hw/rtl/dss_datapath.sv
// Datapath of the drum step sequencer: registers, pattern memory, note events.
// Driven by dss_ctrl through dss_cmd_t; depends on dss_pkg.
`timescale 1ns / 1ps

module dss_datapath
	import dss_pkg::*;
#(
	parameter int TRACKS    = DEF_TRACKS,
	parameter int MAX_STEPS = DEF_MAX_STEPS
) (
	input  logic             clk,
	input  logic             arst_n,
	input  dss_cmd_t         ctl,
	output dss_status_t      sts,
	input  logic             cfg_write,
	input  logic [1:0]       cfg_index,
	input  logic [CFG_W-1:0] cfg_data,
	input  logic [2:0]       cmd,
	input  logic [3:0]       track,
	input  logic [5:0]       step_index,
	input  logic [POT_W-1:0] pot_value,
	input  logic             switch_on,
	output logic             result_valid,
	output logic             kind,
	output logic [3:0]       voice,
	output logic [6:0]       pitch,
	output logic [VEL_W-1:0] velocity,
	output logic [5:0]       current_step,
	output logic             last
);

	localparam int STEP_W = $clog2(MAX_STEPS);
	localparam int CNT_W  = (TRACKS > 1) ? $clog2(TRACKS) : 1;
	localparam int ROW_W  = TRACKS * VEL_W;
	localparam int CMP_W  = (STEP_W + 1 > 7) ? STEP_W + 1 : 7;

	// Configuration
	logic [6:0] pattern_len_q;
	logic [4:0] clock_div_q;
	logic       sync_en_q;

	// Sequencer state
	logic [STEP_W-1:0] play_step_q;
	logic [STEP_W-1:0] off_step_q;
	logic              running_q;
	logic              switch_last_q;
	logic              ext_active_q;
	logic [4:0]        tick_q;
	logic              sel_valid_q;
	logic [CNT_W-1:0]  sel_trk_q;
	logic [STEP_W-1:0] sel_step_q;
	logic [POT_W-1:0]  last_pot_q;
	logic [CNT_W-1:0]  cnt_q;

	// Key and pot transfer payload
	logic [CNT_W-1:0]  key_trk_q;
	logic [STEP_W-1:0] key_step_q;
	logic [PROD_W-1:0] prod_s1;

	// Pattern memory: one row per step, one lane per track
	logic [ROW_W-1:0]     pat_mem_q [MAX_STEPS];
	logic [MAX_STEPS-1:0] row_vld_q;
	logic [ROW_W-1:0]     rd_row_s1;
	logic                 rd_vld_s1;

	logic [5:0]        tick_inc;
	logic              clk_adv;
	logic              adv_go;
	logic              key_go;
	logic              pot_go;
	logic [CMP_W-1:0]  len_cap;
	logic [CMP_W-1:0]  step_inc;
	logic [STEP_W-1:0] next_step;
	logic              rd_en;
	logic [STEP_W-1:0] rd_addr;
	logic              wr_en;
	logic [STEP_W-1:0] wr_addr;
	logic [CNT_W-1:0]  wr_lane;
	logic [VEL_W-1:0]  wr_vel;
	logic [ROW_W-1:0]  wr_row;
	logic [VEL_W-1:0]  lane_vel [TRACKS];
	logic [TRACKS-1:0] lane_nz;
	logic [TRACKS-1:0] lane_above;
	logic [VEL_W-1:0]  cnt_vel;
	logic [VEL_W-1:0]  key_old;
	logic [VEL_W-1:0]  key_new;
	logic [VEL_W-1:0]  pot_scaled;
	logic              cnt_last;
	logic              row_any;
	logic              above_any;
	logic              is_key;

	// Decide what the offered command does
	assign tick_inc = {1'b0, tick_q} + 6'd1;
	assign clk_adv  = sync_en_q && running_q && (tick_inc >= {1'b0, clock_div_q});
	assign adv_go   = ((cmd == CMD_MIDI_CLOCK) && clk_adv) ||
		((cmd == CMD_INT_TICK) && running_q && !ext_active_q);
	assign key_go   = (cmd == CMD_KEY) && ({1'b0, track} < 5'(TRACKS)) &&
		({3'b000, step_index} < 9'(MAX_STEPS));
	assign pot_go   = (cmd == CMD_POT) && (pot_value != last_pot_q) && sel_valid_q;

	// Wrap the step at the capped loop length
	assign len_cap   = (CMP_W'(pattern_len_q) >= CMP_W'(MAX_STEPS)) ?
		CMP_W'(MAX_STEPS) : CMP_W'(pattern_len_q);
	assign step_inc  = CMP_W'(play_step_q) + CMP_W'(1);
	assign next_step = (step_inc < len_cap) ? STEP_W'(step_inc) : '0;

	// Select the row to read
	assign rd_en = ctl.accept && (adv_go || key_go || pot_go);
	always_comb begin
		priority if (adv_go) begin
			rd_addr = next_step;
		end else if (key_go) begin
			rd_addr = STEP_W'(step_index);
		end else begin
			rd_addr = sel_step_q;
		end
	end

	// Split the read row into lanes; an unwritten row reads as zero
	genvar gi;
	generate
		for (gi = 0; gi < TRACKS; gi++) begin : g_lane
			assign lane_vel[gi]   = rd_vld_s1 ? rd_row_s1[gi*VEL_W +: VEL_W] : '0;
			assign lane_nz[gi]    = (lane_vel[gi] != '0);
			assign lane_above[gi] = (CNT_W'(gi) > cnt_q);
			assign wr_row[gi*VEL_W +: VEL_W] =
				(CNT_W'(gi) == wr_lane) ? wr_vel : lane_vel[gi];
		end
	endgenerate

	assign row_any   = |lane_nz;
	assign above_any = |(lane_nz & lane_above);
	assign cnt_vel   = lane_vel[cnt_q];
	assign cnt_last  = (cnt_q == CNT_W'(TRACKS - 1));

	// Toggle for a key, rescale for the pot
	assign key_old    = lane_vel[key_trk_q];
	assign key_new    = (key_old == '0) ? KEY_VEL : '0;
	assign pot_scaled = prod_s1[PROD_W-1:POT_SHIFT] + 7'd1;

	assign wr_en   = ctl.emit_key || ctl.pot_write;
	assign wr_addr = ctl.emit_key ? key_step_q : sel_step_q;
	assign wr_lane = ctl.emit_key ? key_trk_q : sel_trk_q;
	assign wr_vel  = ctl.emit_key ? key_new : pot_scaled;

	// Write and read the pattern memory
	always_ff @(posedge clk) begin
		if (wr_en) begin
			pat_mem_q[wr_addr] <= wr_row;
		end
		if (rd_en) begin
			rd_row_s1 <= pat_mem_q[rd_addr];
		end
	end

	// Mark rows as written; reset clears every row's valid bit at once, so the pattern reads as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			if (wr_en) begin
				row_vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_s1 <= row_vld_q[rd_addr];
			end
		end
	end

	// Capture key and pot payload
	always_ff @(posedge clk) begin
		if (ctl.accept && key_go) begin
			key_trk_q  <= CNT_W'(track);
			key_step_q <= STEP_W'(step_index);
		end
		if (ctl.accept && pot_go) begin
			prod_s1 <= PROD_W'(pot_value) * PROD_W'(POT_RECIP);
		end
	end

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_len_q <= LEN_RESET;
			clock_div_q   <= DIV_RESET;
			sync_en_q     <= 1'b0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_PATTERN_LENGTH:   pattern_len_q <= cfg_data[6:0];
				REG_CLOCK_DIVIDE:     clock_div_q   <= cfg_data[4:0];
				REG_MIDI_SYNC_ENABLE: sync_en_q     <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Update sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			play_step_q   <= '0;
			off_step_q    <= '0;
			running_q     <= 1'b0;
			switch_last_q <= 1'b0;
			ext_active_q  <= 1'b0;
			tick_q        <= '0;
			sel_valid_q   <= 1'b0;
			sel_trk_q     <= '0;
			sel_step_q    <= '0;
			last_pot_q    <= '0;
		end else begin
			if (ctl.accept) begin
				if (adv_go) begin
					off_step_q  <= play_step_q;
					play_step_q <= next_step;
				end
				unique case (cmd)
					CMD_MIDI_CLOCK: begin
						if (sync_en_q && running_q) begin
							ext_active_q <= 1'b1;
							tick_q       <= clk_adv ? 5'd0 : tick_inc[4:0];
						end
					end
					CMD_MIDI_STOP: begin
						if (sync_en_q) begin
							ext_active_q <= 1'b0;
							tick_q       <= '0;
						end
					end
					CMD_POT: begin
						if (pot_go) begin
							last_pot_q <= pot_value;
						end
					end
					CMD_SWITCH: begin
						// Restart on every rise of the run switch
						if (switch_on && !switch_last_q) begin
							sel_valid_q <= 1'b0;
							play_step_q <= '0;
						end
						running_q     <= switch_on;
						switch_last_q <= switch_on;
					end
					default: ;
				endcase
			end
			if (ctl.emit_key) begin
				sel_trk_q   <= key_trk_q;
				sel_step_q  <= key_step_q;
				sel_valid_q <= (key_new != '0);
			end
		end
	end

	// Advance the track counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			priority if (ctl.cnt_clear) begin
				cnt_q <= '0;
			end else if (ctl.cnt_inc && !cnt_last) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
		end
	end

	// Drive the note event
	assign is_key       = ctl.emit_key;
	assign result_valid = ctl.emit_off || (ctl.emit_on && lane_nz[cnt_q]) || ctl.emit_key;
	assign kind         = !ctl.emit_off;
	assign voice        = is_key ? 4'(key_trk_q) : 4'(cnt_q);
	assign pitch        = PITCH_BASE - {2'b00, voice, 1'b0};
	assign current_step = ctl.emit_off ? 6'(off_step_q) : 6'(play_step_q);

	always_comb begin
		priority if (ctl.emit_off) begin
			velocity = '0;
			last     = cnt_last && !row_any;
		end else if (ctl.emit_on) begin
			velocity = cnt_vel;
			last     = !above_any;
		end else begin
			velocity = PRESS_VEL;
			last     = 1'b1;
		end
	end

	// Report to the controller
	assign sts.adv_go   = adv_go;
	assign sts.key_go   = key_go;
	assign sts.pot_go   = pot_go;
	assign sts.cnt_last = cnt_last;
	assign sts.row_any  = row_any;

endmodule

FILE: hw/rtl/drum_step_sequencer.sv
// Drum step sequencer top level: dss_ctrl and dss_datapath; depends on dss_pkg.
// Step advance: busy for a note-off per track, then a scan of all tracks if any hit,
// first event in the cycle after the transfer. Key press: busy while its event is out.
// Pot update: busy while writing. Other commands take effect at once, busy staying low.
// Reset clears every row's valid bit at once, so the pattern reads as zero with no pass.
`timescale 1ns / 1ps

module drum_step_sequencer
	import dss_pkg::*;
#(
	parameter int TRACKS    = DEF_TRACKS,
	parameter int MAX_STEPS = DEF_MAX_STEPS
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  logic             cfg_write,
	input  logic [1:0]       cfg_index,
	input  logic [CFG_W-1:0] cfg_data,
	input  logic [2:0]       cmd,
	input  logic [3:0]       track,
	input  logic [5:0]       step_index,
	input  logic [POT_W-1:0] pot_value,
	input  logic             switch_on,
	output logic             result_valid,
	output logic             kind,
	output logic [3:0]       voice,
	output logic [6:0]       pitch,
	output logic [VEL_W-1:0] velocity,
	output logic [5:0]       current_step,
	output logic             last
);

	dss_cmd_t    ctl;
	dss_status_t sts;

	// Sequence the work
	dss_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.sts    (sts),
		.ctl    (ctl)
	);

	// Hold state and pattern, build note events
	dss_datapath #(
		.TRACKS    (TRACKS),
		.MAX_STEPS (MAX_STEPS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (ctl),
		.sts          (sts),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.cmd          (cmd),
		.track        (track),
		.step_index   (step_index),
		.pot_value    (pot_value),
		.switch_on    (switch_on),
		.result_valid (result_valid),
		.kind         (kind),
		.voice        (voice),
		.pitch        (pitch),
		.velocity     (velocity),
		.current_step (current_step),
		.last         (last)
	);

endmodule

FILE: sim/drum_step_sequencer_tb.sv
// Self-checking testbench for drum_step_sequencer: command and register-write traffic,
// note events checked against a scoreboard that tracks the pattern and step state.
// Depends on dss_pkg and the drum_step_sequencer RTL.
`timescale 1ns / 1ps

module drum_step_sequencer_tb;
	import dss_pkg::*;

	localparam int TRACK_COUNT = DEF_TRACKS;
	localparam int STEP_COUNT  = DEF_MAX_STEPS;
	localparam int POT_SPAN    = 126;
	localparam int POT_DIV     = 1027;
	localparam int SETTLE      = 40;
	localparam int LIMIT       = 300000;
	localparam int MAX_REPORTS = 10;

	localparam logic [2:0] CMD_SPARE_LO = 3'd6;
	localparam logic [2:0] CMD_SPARE_HI = 3'd7;
	localparam logic       NOTE_OFF     = 1'b0;
	localparam logic       NOTE_ON      = 1'b1;

	typedef struct packed {
		logic             kind;
		logic [3:0]       voice;
		logic [6:0]       pitch;
		logic [VEL_W-1:0] velocity;
		logic [5:0]       current_step;
		logic             last;
	} note_event_t;

	typedef struct packed {
		logic [2:0]       cmd;
		logic [3:0]       track;
		logic [5:0]       step;
		logic [POT_W-1:0] pot;
		logic             sw;
	} command_t;

	// Tracks pattern, play position and selection; queues the note events each command causes
	class note_event_board;
		note_event_t      pending_notes[$];
		int unsigned      errors;
		logic [VEL_W-1:0] velocity_map [TRACK_COUNT*STEP_COUNT];
		int unsigned      play_step;
		int unsigned      tick_count;
		bit               running;
		bit               switch_last;
		bit               ext_active;
		bit               sel_valid;
		logic [3:0]       sel_track;
		logic [5:0]       sel_step;
		logic [POT_W-1:0] last_pot;
		logic [6:0]       loop_length;
		logic [4:0]       divide;
		bit               sync_on;

		function new();
			foreach (velocity_map[i])
				velocity_map[i] = '0;
			errors      = 0;
			play_step   = 0;
			tick_count  = 0;
			running     = 0;
			switch_last = 0;
			ext_active  = 0;
			sel_valid   = 0;
			sel_track   = '0;
			sel_step    = '0;
			last_pot    = '0;
			loop_length = LEN_RESET;
			divide      = DIV_RESET;
			sync_on     = 0;
		endfunction

		function void write_reg(logic [1:0] idx, logic [6:0] val);
			case (idx)
				REG_PATTERN_LENGTH:   loop_length = val;
				REG_CLOCK_DIVIDE:     divide = val[4:0];
				REG_MIDI_SYNC_ENABLE: sync_on = val[0];
				default: ;
			endcase
		endfunction

		function void push_note(logic k, int unsigned t, logic [VEL_W-1:0] vel,
				int unsigned st, logic fin);
			note_event_t n;
			n.kind         = k;
			n.voice        = 4'(t);
			n.pitch        = PITCH_BASE - 7'(2 * t);
			n.velocity     = vel;
			n.current_step = 6'(st);
			n.last         = fin;
			pending_notes.push_back(n);
		endfunction

		// Note-offs on the old step, move on with wrap, note-ons for every hit on the new step
		function void step_advance();
			int unsigned span;
			int unsigned nxt;
			int          last_on;
			span = (loop_length < STEP_COUNT) ? loop_length : STEP_COUNT;
			nxt = (play_step + 1 < span) ? play_step + 1 : 0;
			last_on = -1;
			for (int t = 0; t < TRACK_COUNT; t++)
				if (velocity_map[t*STEP_COUNT + nxt] != 0)
					last_on = t;
			for (int t = 0; t < TRACK_COUNT; t++)
				push_note(NOTE_OFF, t, '0, play_step, last_on < 0 && t == TRACK_COUNT - 1);
			play_step = nxt;
			for (int t = 0; t < TRACK_COUNT; t++)
				if (velocity_map[t*STEP_COUNT + nxt] != 0)
					push_note(NOTE_ON, t, velocity_map[t*STEP_COUNT + nxt], play_step,
						t == last_on);
		endfunction

		function void take_command(command_t c);
			int unsigned idx;
			case (c.cmd)
				CMD_MIDI_CLOCK: begin
					if (sync_on && running) begin
						ext_active = 1;
						tick_count = (tick_count + 1) & 63;
						if (tick_count >= divide) begin
							tick_count = 0;
							step_advance();
						end
					end
				end
				CMD_MIDI_STOP: begin
					if (sync_on) begin
						ext_active = 0;
						tick_count = 0;
					end
				end
				CMD_INT_TICK: begin
					if (running && !ext_active)
						step_advance();
				end
				CMD_KEY: begin
					idx = c.track * STEP_COUNT + c.step;
					velocity_map[idx] = (velocity_map[idx] == 0) ? KEY_VEL : '0;
					sel_track = c.track;
					sel_step  = c.step;
					sel_valid = velocity_map[idx] != 0;
					push_note(NOTE_ON, c.track, PRESS_VEL, play_step, 1'b1);
				end
				CMD_POT: begin
					if (c.pot != last_pot && sel_valid) begin
						velocity_map[sel_track*STEP_COUNT + sel_step] =
							VEL_W'((int'(c.pot) * POT_SPAN) / POT_DIV + 1);
						last_pot = c.pot;
					end
				end
				CMD_SWITCH: begin
					if (c.sw && !switch_last) begin
						sel_valid = 0;
						play_step = 0;
					end
					running     = c.sw;
					switch_last = c.sw;
				end
				default: ;
			endcase
		endfunction

		function void match_note(note_event_t got);
			note_event_t want;
			if (pending_notes.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("unexpected note event: kind %0d voice %0d pitch %0d vel %0d step %0d last %0d",
						got.kind, got.voice, got.pitch, got.velocity, got.current_step, got.last);
				return;
			end
			want = pending_notes.pop_front();
			if (got.kind !== want.kind || got.voice !== want.voice ||
					got.pitch !== want.pitch || got.velocity !== want.velocity ||
					got.current_step !== want.current_step || got.last !== want.last) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("note mismatch: expected kind %0d voice %0d pitch %0d vel %0d step %0d last %0d, got kind %0d voice %0d pitch %0d vel %0d step %0d last %0d",
						want.kind, want.voice, want.pitch, want.velocity, want.current_step,
						want.last, got.kind, got.voice, got.pitch, got.velocity,
						got.current_step, got.last);
			end
		endfunction
	endclass

	logic             clk;
	logic             arst_n;
	logic             start;
	logic             busy;
	logic             cfg_write;
	logic [1:0]       cfg_index;
	logic [CFG_W-1:0] cfg_data;
	logic [2:0]       cmd;
	logic [3:0]       track;
	logic [5:0]       step_index;
	logic [POT_W-1:0] pot_value;
	logic             switch_on;
	logic             result_valid;
	logic             kind;
	logic [3:0]       voice;
	logic [6:0]       pitch;
	logic [VEL_W-1:0] velocity;
	logic [5:0]       current_step;
	logic             last;

	note_event_board board;
	bit              allow_gaps;
	int unsigned     cycle_count;

	drum_step_sequencer DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.cmd          (cmd),
		.track        (track),
		.step_index   (step_index),
		.pot_value    (pot_value),
		.switch_on    (switch_on),
		.result_valid (result_valid),
		.kind         (kind),
		.voice        (voice),
		.pitch        (pitch),
		.velocity     (velocity),
		.current_step (current_step),
		.last         (last)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Check note events and record command transfers at each edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid)
				board.match_note({kind, voice, pitch, velocity, current_step, last});
			if (start && !busy)
				board.take_command({cmd, track, step_index, pot_value, switch_on});
		end
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= LIMIT) begin
			$display("FAIL drum_step_sequencer");
			$finish;
		end
	end

	// Present one command, with an optional idle burst first, and hold it until the transfer
	task automatic send_command(input logic [2:0] c, input logic [3:0] t,
			input logic [5:0] s, input logic [POT_W-1:0] p, input logic sw);
		if (allow_gaps && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		start      <= 1'b1;
		cmd        <= c;
		track      <= t;
		step_index <= s;
		pot_value  <= p;
		switch_on  <= sw;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	task automatic random_command();
		int unsigned pick;
		int unsigned span;
		logic [2:0]  c;
		logic [5:0]  s;
		logic        sw;
		pick = $urandom_range(0, 99);
		if (pick < 25)
			c = CMD_MIDI_CLOCK;
		else if (pick < 45)
			c = CMD_INT_TICK;
		else if (pick < 68)
			c = CMD_KEY;
		else if (pick < 80)
			c = CMD_POT;
		else if (pick < 90)
			c = CMD_SWITCH;
		else if (pick < 95)
			c = CMD_MIDI_STOP;
		else
			c = pick[0] ? CMD_SPARE_HI : CMD_SPARE_LO;
		span = (board.loop_length < STEP_COUNT) ? board.loop_length : STEP_COUNT;
		if (span == 0)
			span = 1;
		s = 6'($urandom_range(0, STEP_COUNT - 1));
		// Keep most key presses inside the loop so hits get played back
		if (c == CMD_KEY && $urandom_range(0, 4) != 0)
			s = 6'($urandom_range(0, span - 1));
		sw = 1'($urandom_range(0, 1));
		if (c == CMD_SWITCH)
			sw = $urandom_range(0, 4) != 0;
		send_command(c, 4'($urandom_range(0, 15)), s, POT_W'($urandom_range(0, 1023)), sw);
	endtask

	// Drain the block, then write all three registers; spare high data bits are junk
	task automatic set_registers(input logic [6:0] len, input logic [4:0] div, input logic sync);
		logic [1:0] idx [3];
		logic [6:0] val [3];
		idx[0] = REG_PATTERN_LENGTH;
		val[0] = len;
		idx[1] = REG_CLOCK_DIVIDE;
		val[1] = {2'($urandom_range(0, 3)), div};
		idx[2] = REG_MIDI_SYNC_ENABLE;
		val[2] = {6'($urandom_range(0, 63)), sync};
		start <= 1'b0;
		@(posedge clk);
		while (board.pending_notes.size() != 0 || busy)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		for (int i = 0; i < 3; i++) begin
			cfg_write <= 1'b1;
			cfg_index <= idx[i];
			cfg_data  <= val[i];
			@(posedge clk);
			board.write_reg(idx[i], val[i]);
		end
		cfg_write <= 1'b0;
	endtask

	initial begin
		board       = new();
		cycle_count = 0;
		allow_gaps  = 1;
		arst_n      = 1'b0;
		start       = 1'b0;
		cfg_write   = 1'b0;
		cfg_index   = '0;
		cfg_data    = '0;
		cmd         = CMD_MIDI_CLOCK;
		track       = '0;
		step_index  = '0;
		pot_value   = '0;
		switch_on   = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reset configuration, stopped block, ignored and unused commands
		send_command(CMD_POT, 4'd0, 6'd0, 10'd1023, 1'b0);
		send_command(CMD_INT_TICK, 4'd0, 6'd0, 10'd0, 1'b0);
		send_command(CMD_SPARE_LO, 4'd15, 6'd63, 10'd1023, 1'b1);
		send_command(CMD_SPARE_HI, 4'd15, 6'd63, 10'd1023, 1'b1);
		send_command(CMD_MIDI_CLOCK, 4'd0, 6'd0, 10'd0, 1'b1);
		send_command(CMD_MIDI_STOP, 4'd0, 6'd0, 10'd0, 1'b0);
		send_command(CMD_SWITCH, 4'd0, 6'd0, 10'd0, 1'b1);
		// Key toggles, pot rescale at both ends, unchanged pot, toggle off
		send_command(CMD_KEY, 4'd0, 6'd1, 10'd0, 1'b0);
		send_command(CMD_POT, 4'd0, 6'd0, 10'd0, 1'b0);
		send_command(CMD_POT, 4'd0, 6'd0, 10'd1023, 1'b0);
		send_command(CMD_KEY, 4'd15, 6'd63, 10'd0, 1'b0);
		send_command(CMD_POT, 4'd0, 6'd0, 10'd1, 1'b0);
		send_command(CMD_KEY, 4'd15, 6'd63, 10'd0, 1'b0);
		send_command(CMD_POT, 4'd0, 6'd0, 10'd512, 1'b0);
		send_command(CMD_KEY, 4'd7, 6'd2, 10'd0, 1'b0);
		// Internal ticks, repeated switch level, stop and restart
		send_command(CMD_INT_TICK, 4'd0, 6'd0, 10'd0, 1'b0);
		send_command(CMD_INT_TICK, 4'd0, 6'd0, 10'd0, 1'b0);
		send_command(CMD_SWITCH, 4'd0, 6'd0, 10'd0, 1'b1);
		send_command(CMD_SWITCH, 4'd0, 6'd0, 10'd0, 1'b0);
		send_command(CMD_INT_TICK, 4'd0, 6'd0, 10'd0, 1'b0);
		send_command(CMD_SWITCH, 4'd0, 6'd0, 10'd0, 1'b1);
		send_command(CMD_INT_TICK, 4'd0, 6'd0, 10'd0, 1'b0);
		send_command(CMD_INT_TICK, 4'd0, 6'd0, 10'd0, 1'b0);
		send_command(CMD_INT_TICK, 4'd0, 6'd0, 10'd0, 1'b0);
		// Shorten the loop under the play position, MIDI sync with divide of zero
		set_registers(7'd2, 5'd0, 1'b1);
		send_command(CMD_MIDI_CLOCK, 4'd0, 6'd0, 10'd0, 1'b1);
		send_command(CMD_INT_TICK, 4'd0, 6'd0, 10'd0, 1'b1);
		send_command(CMD_MIDI_STOP, 4'd0, 6'd0, 10'd0, 1'b1);
		send_command(CMD_INT_TICK, 4'd0, 6'd0, 10'd0, 1'b1);
		send_command(CMD_MIDI_CLOCK, 4'd0, 6'd0, 10'd0, 1'b1);
		send_command(CMD_SWITCH, 4'd0, 6'd0, 10'd0, 1'b0);
		send_command(CMD_MIDI_CLOCK, 4'd0, 6'd0, 10'd0, 1'b0);
		send_command(CMD_SWITCH, 4'd0, 6'd0, 10'd0, 1'b1);
		send_command(CMD_INT_TICK, 4'd0, 6'd0, 10'd0, 1'b1);

		// Random traffic over several register settings; the last phase runs without gaps
		for (int ph = 0; ph < 6; ph++) begin
			allow_gaps = ph < 5;
			send_command(CMD_MIDI_STOP, 4'd0, 6'd0, 10'd0, 1'b1);
			case (ph)
				0: set_registers(7'd2, 5'd1, 1'b1);
				1: set_registers(7'd64, 5'd24, 1'b0);
				2: set_registers(7'd127, 5'd0, 1'b1);
				3: set_registers(7'd1, 5'd31, 1'b1);
				4: set_registers(7'd0, 5'($urandom_range(1, 24)), 1'b0);
				default: set_registers(7'($urandom_range(2, 64)), 5'($urandom_range(1, 24)),
					1'($urandom_range(0, 1)));
			endcase
			send_command(CMD_SWITCH, 4'($urandom_range(0, 15)), 6'($urandom_range(0, 63)),
				POT_W'($urandom_range(0, 1023)), 1'b1);
			repeat (70) random_command();
		end

		// Let the last events drain, then give the block time to show stray output
		start <= 1'b0;
		while (board.pending_notes.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (board.errors == 0 && board.pending_notes.size() == 0)
			$display("PASS drum_step_sequencer");
		else
			$display("FAIL drum_step_sequencer");
		$finish;
	end

endmodule
